[rtl/mcbf_pkg.sv]
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types and constants for the multi-channel byte FIFO pool.
// ----------------------------------------------------------------------------
package mcbf_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int DEPTH        = 1024;
    localparam int CH_W         = 4;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int REM_W        = $clog2(DEPTH + 1);
    localparam int MEM_DEPTH    = NUM_CHANNELS * DEPTH;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    localparam logic [2:0] REQ_CREATE      = 3'd0;
    localparam logic [2:0] REQ_WRITE_START = 3'd1;
    localparam logic [2:0] REQ_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] REQ_READ_START  = 3'd3;
    localparam logic [2:0] REQ_READ_BYTE   = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LONG    = 3'd1;
    localparam logic [2:0] ST_NO_ROOM     = 3'd2;
    localparam logic [2:0] ST_NO_FREE     = 3'd3;
    localparam logic [2:0] ST_BAD_CHANNEL = 3'd4;
    localparam logic [2:0] ST_NO_XFER     = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  channel;
        logic [15:0] length;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  channel_out;
        logic [15:0] count;
        logic [7:0]  data_out;
        logic        last;
    } resp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

[rtl/multi_channel_byte_fifo_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_unit
// Pool of sixteen 1024-byte ring FIFOs driven by a request/response stream.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready): create, write start,
// write byte, read start, read byte. Each request yields exactly one
// response on the m_ channel, in request order.
// Each request passes through the sequencer states in order: S_IDLE takes
// the transfer, S_EXEC executes it against the pointer registers and the
// byte storage (one storage port access, read data registered), S_RESP
// presents the response. A new request is taken in the cycle after the
// response transfer completes, so none is taken while a response waits.
// While the receiver stalls, the response holds steady and s_ready stays
// low. Reset clears allocation flags, ring pointers and the open write and
// read transfers; storage contents are not cleared and are only ever read
// after being written.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mcbf_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mcbf_pkg::resp_t m_data
);
    import mcbf_pkg::*;

    cmd_t cmd;

    mcbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mcbf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .req_in   (s_data),
        .resp_out (m_data)
    );

endmodule

[rtl/mcbf_ctrl.sv]
// ----------------------------------------------------------------------------
// mcbf_ctrl
// Sequencer: accept one request, execute it, hold the response until taken.
// ----------------------------------------------------------------------------
module mcbf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output mcbf_pkg::cmd_t cmd
);
    import mcbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/mcbf_datapath.sv]
// ----------------------------------------------------------------------------
// mcbf_datapath
// Allocation flags, ring pointers, open transfers and byte storage.
// ----------------------------------------------------------------------------
module mcbf_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  mcbf_pkg::cmd_t  cmd,
    input  mcbf_pkg::req_t  req_in,
    output mcbf_pkg::resp_t resp_out
);
    import mcbf_pkg::*;

    req_t              item_reg;
    resp_t             res_reg, res_next;
    logic              rd_sel_reg, rd_sel_next;
    logic [7:0]        rd_data_reg;

    logic [NUM_CHANNELS-1:0] in_use_reg;
    logic [IDX_W-1:0]  widx_reg [NUM_CHANNELS];
    logic [IDX_W-1:0]  ridx_reg [NUM_CHANNELS];
    logic [CH_W-1:0]   wch_reg, rch_reg;
    logic [REM_W-1:0]  wrem_reg, rrem_reg;

    logic [7:0]        mem [MEM_DEPTH];
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;

    logic [CH_W-1:0]   free_ch;
    logic              free_found;
    logic [CH_W-1:0]   sel_ch;
    logic [IDX_W-1:0]  sel_wi, sel_ri;
    logic [REM_W-1:0]  fill, room, grant;
    logic              ch_ok;
    logic [IDX_W-1:0]  wi_inc, ri_inc;

    // lowest free channel
    always_comb begin
        free_found = 1'b0;
        free_ch    = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_ch    = CH_W'(i);
            end
        end
    end

    always_comb begin
        case (item_reg.req_type)
            REQ_WRITE_BYTE: sel_ch = wch_reg;
            REQ_READ_BYTE:  sel_ch = rch_reg;
            default:        sel_ch = item_reg.channel;
        endcase
    end

    assign sel_wi = widx_reg[sel_ch];
    assign sel_ri = ridx_reg[sel_ch];
    assign fill   = (sel_wi >= sel_ri) ? REM_W'(sel_wi - sel_ri)
                                       : REM_W'(DEPTH) - REM_W'(sel_ri) + REM_W'(sel_wi);
    assign room   = REM_W'(DEPTH - 1) - fill;
    assign grant  = ({5'd0, item_reg.length} < 21'(fill)) ? REM_W'(item_reg.length) : fill;
    assign ch_ok  = (int'(item_reg.channel) < NUM_CHANNELS) && in_use_reg[item_reg.channel];
    assign wi_inc = (sel_wi == IDX_W'(DEPTH - 1)) ? '0 : sel_wi + 1'b1;
    assign ri_inc = (sel_ri == IDX_W'(DEPTH - 1)) ? '0 : sel_ri + 1'b1;

    always_comb begin
        res_next             = res_reg;
        rd_sel_next          = rd_sel_reg;
        mem_we               = 1'b0;
        mem_re               = 1'b0;
        mem_addr             = MEM_AW'(int'(sel_ch) * DEPTH) + MEM_AW'(sel_wi);
        if (cmd.exec) begin
            res_next             = '0;
            res_next.status      = ST_NO_XFER;
            res_next.channel_out = item_reg.channel;
            rd_sel_next          = 1'b0;
            case (item_reg.req_type)
                REQ_CREATE: begin
                    res_next.status      = free_found ? ST_OK : ST_NO_FREE;
                    res_next.channel_out = free_found ? free_ch : '0;
                end
                REQ_WRITE_START, REQ_READ_START: begin
                    if (!ch_ok) begin
                        res_next.status = ST_BAD_CHANNEL;
                    end else if (32'(item_reg.length) > DEPTH) begin
                        res_next.status = ST_TOO_LONG;
                    end else if (item_reg.req_type == REQ_WRITE_START) begin
                        if (17'(item_reg.length) > 17'(room)) begin
                            res_next.status = ST_NO_ROOM;
                        end else begin
                            res_next.status = ST_OK;
                            res_next.count  = item_reg.length;
                        end
                    end else begin
                        res_next.status = ST_OK;
                        res_next.count  = 16'(grant);
                    end
                end
                REQ_WRITE_BYTE: begin
                    res_next.channel_out = wch_reg;
                    if (wrem_reg != '0) begin
                        res_next.status = ST_OK;
                        res_next.last   = (wrem_reg == REM_W'(1));
                        mem_we          = 1'b1;
                    end
                end
                REQ_READ_BYTE: begin
                    res_next.channel_out = rch_reg;
                    mem_addr             = MEM_AW'(int'(sel_ch) * DEPTH) + MEM_AW'(sel_ri);
                    if (rrem_reg != '0) begin
                        res_next.status = ST_OK;
                        res_next.last   = (rrem_reg == REM_W'(1));
                        mem_re          = 1'b1;
                        rd_sel_next     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= req_in;
        end
        res_reg    <= res_next;
        rd_sel_reg <= rd_sel_next;
        if (mem_we) begin
            mem[mem_addr] <= item_reg.data_byte;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            wch_reg    <= '0;
            rch_reg    <= '0;
            wrem_reg   <= '0;
            rrem_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                widx_reg[i] <= '0;
                ridx_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            case (item_reg.req_type)
                REQ_CREATE: begin
                    if (free_found) begin
                        in_use_reg[free_ch] <= 1'b1;
                        widx_reg[free_ch]   <= '0;
                        ridx_reg[free_ch]   <= '0;
                    end
                end
                REQ_WRITE_START: begin
                    if (ch_ok && 32'(item_reg.length) <= DEPTH
                        && 17'(item_reg.length) <= 17'(room)) begin
                        wch_reg  <= item_reg.channel;
                        wrem_reg <= REM_W'(item_reg.length);
                    end
                end
                REQ_READ_START: begin
                    if (ch_ok && 32'(item_reg.length) <= DEPTH) begin
                        rch_reg  <= item_reg.channel;
                        rrem_reg <= grant;
                    end
                end
                REQ_WRITE_BYTE: begin
                    if (wrem_reg != '0) begin
                        widx_reg[sel_ch] <= wi_inc;
                        wrem_reg         <= wrem_reg - 1'b1;
                    end
                end
                REQ_READ_BYTE: begin
                    if (rrem_reg != '0) begin
                        ridx_reg[sel_ch] <= ri_inc;
                        rrem_reg         <= rrem_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        resp_out          = res_reg;
        resp_out.data_out = rd_sel_reg ? rd_data_reg : 8'd0;
    end

endmodule
